// ===== rtl/cuuq_pkg.sv =====
// ----------------------------------------------------------------------------
// cuuq_pkg
// Shared types and constants for the coalescing urgent update queue: request
// and response payloads, the stored entry record, status codes, sequencer
// states and the control handshake between the top level and the sequencer.
// ----------------------------------------------------------------------------
package cuuq_pkg;

    // Default number of queue entries
    localparam int QUEUE_DEPTH_DEF = 16;

    // Request mode codes
    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_POP = 1'b1;

    // Response status codes
    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_MERGED   = 3'd1,
        ST_FULL     = 3'd2,
        ST_POPPED   = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_POP_SCAN,
        S_POP_SHIFT,
        S_DONE
    } t_state;

    // Input request payload
    typedef struct packed {
        logic               mode;
        logic signed [11:0] block_x;
        logic signed [11:0] block_y;
        logic signed [11:0] block_z;
        logic               notify_logic;
        logic               is_urgent;
        logic signed [7:0]  crack_stage;
        logic signed [15:0] crack_x;
        logic signed [15:0] crack_y;
        logic signed [15:0] crack_z;
    } t_req;

    // Output response payload
    typedef struct packed {
        t_status            status;
        logic signed [11:0] out_block_x;
        logic signed [11:0] out_block_y;
        logic signed [11:0] out_block_z;
        logic               out_notify_logic;
        logic signed [7:0]  out_crack_stage;
        logic signed [15:0] out_crack_x;
        logic signed [15:0] out_crack_y;
        logic signed [15:0] out_crack_z;
    } t_rsp;

    // One stored queue entry
    typedef struct packed {
        logic [11:0] block_x;
        logic [11:0] block_y;
        logic [11:0] block_z;
        logic        notify;
        logic        urgent;
        logic [7:0]  crack_stage;
        logic [15:0] crack_x;
        logic [15:0] crack_y;
        logic [15:0] crack_z;
    } t_entry;

    // Sequencer status toward the top level
    typedef struct packed {
        logic done;
        logic idle;
    } t_ctrl_sts;

endpackage

// ===== rtl/coalescing_urgent_update_queue_unit.sv =====
// An add scans the waiting entries until it finds a matching position and merges into it,
// else appends at the tail (or reports full). A pop scans for the oldest urgent entry, then
// shifts every later entry up by one place; with nothing urgent it takes the head entry and
// shifts the whole queue. A pop on an empty queue goes straight to its response.
// One request at a time; the next can be taken in the cycle after the response loads; a stalled
// response holds the sequencer. Reset clears the count and control state, not the entry RAM.
// ----------------------------------------------------------------------------
// coalescing_urgent_update_queue_unit
// Top level: takes one request at a time, hands it to the sequencer and
// holds the response in an output register until it is taken.
// ----------------------------------------------------------------------------
module coalescing_urgent_update_queue_unit #(
    parameter int QUEUE_DEPTH = cuuq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  cuuq_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_stall,
    output cuuq_pkg::t_rsp  o_rsp
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    logic                r_busy, n_busy;
    logic                r_start;
    cuuq_pkg::t_req      r_req;
    logic                r_rsp_valid, n_rsp_valid;
    cuuq_pkg::t_rsp      r_rsp;

    logic                req_acc;
    logic                rsp_ready;
    cuuq_pkg::t_ctrl_sts ctrl_sts;
    cuuq_pkg::t_rsp      ctrl_rsp;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    cuuq_pkg::t_entry    rd_data;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    cuuq_pkg::t_entry    wr_data;

    // Request and response handshake
    always_comb begin
        req_acc     = i_req_valid && !r_busy;
        rsp_ready   = !r_rsp_valid || !i_rsp_stall;
        n_busy      = r_busy;
        n_rsp_valid = r_rsp_valid;
        if (req_acc) begin
            n_busy = 1'b1;
        end else if (ctrl_sts.done && rsp_ready) begin
            n_busy = 1'b0;
        end
        if (ctrl_sts.done && rsp_ready) begin
            n_rsp_valid = 1'b1;
        end else if (!i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_start     <= req_acc;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Capture request, load response
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_req <= i_req;
        end
        if (ctrl_sts.done && rsp_ready) begin
            r_rsp <= ctrl_rsp;
        end
    end

    assign o_req_stall = r_busy;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    cuuq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_start),
        .i_req       (r_req),
        .i_rsp_ready (rsp_ready),
        .o_sts       (ctrl_sts),
        .o_rsp       (ctrl_rsp),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    cuuq_entry_ram #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

`ifndef SYNTHESIS
    // Sequencer finishes only while a request is in work
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_sts.done |-> r_busy)
        else $error("sequencer done without a request in work");

    // A new request starts only on an idle sequencer
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> ctrl_sts.idle)
        else $error("request started on a busy sequencer");

    // An accepted request blocks the next one
    a_acc_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> (o_req_stall && r_start))
        else $error("accepted request did not start work");
`endif

endmodule

// ===== rtl/cuuq_entry_ram.sv =====
// ----------------------------------------------------------------------------
// cuuq_entry_ram
// Entry storage of the queue: one write port and one read port, with the
// read data registered. Contents are undefined until written.
// ----------------------------------------------------------------------------
module cuuq_entry_ram #(
    parameter int QUEUE_DEPTH = cuuq_pkg::QUEUE_DEPTH_DEF,
    localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_addr,
    output cuuq_pkg::t_entry     o_rd_data,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_addr,
    input  cuuq_pkg::t_entry     i_wr_data
);

    cuuq_pkg::t_entry mem [QUEUE_DEPTH];
    cuuq_pkg::t_entry r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/cuuq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cuuq_ctrl
// Sequencer of the queue. Walks the entry RAM one entry per cycle through a
// single shared position/urgent compare: finds a merge target or appends on
// an add, finds the oldest urgent entry on a pop and closes the gap after it.
// ----------------------------------------------------------------------------
module cuuq_ctrl #(
    parameter int QUEUE_DEPTH = cuuq_pkg::QUEUE_DEPTH_DEF,
    localparam int IDX_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  cuuq_pkg::t_req       i_req,
    input  logic                 i_rsp_ready,
    output cuuq_pkg::t_ctrl_sts  o_sts,
    output cuuq_pkg::t_rsp       o_rsp,
    output logic                 o_rd_en,
    output logic [IDX_W-1:0]     o_rd_addr,
    input  cuuq_pkg::t_entry     i_rd_data,
    output logic                 o_wr_en,
    output logic [IDX_W-1:0]     o_wr_addr,
    output cuuq_pkg::t_entry     o_wr_data
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    cuuq_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_pidx, n_pidx;
    logic [IDX_W-1:0]  r_sel, n_sel;
    cuuq_pkg::t_entry  r_ent, n_ent;
    cuuq_pkg::t_status r_status, n_status;

    logic             rd_more;
    logic             drained;
    logic             pos_hit;
    logic             add_hit;
    logic             urg_hit;
    cuuq_pkg::t_entry req_ent;
    cuuq_pkg::t_entry merge_ent;

    // Shared compare and entry formatting
    always_comb begin
        rd_more = (r_idx < r_cnt);
        drained = !r_pend && !rd_more;
        pos_hit = (i_rd_data.block_x == i_req.block_x)
               && (i_rd_data.block_y == i_req.block_y)
               && (i_rd_data.block_z == i_req.block_z);
        add_hit = (r_state == cuuq_pkg::S_ADD_SCAN) && r_pend && pos_hit;
        urg_hit = (r_state == cuuq_pkg::S_POP_SCAN) && r_pend && i_rd_data.urgent;

        req_ent.block_x     = i_req.block_x;
        req_ent.block_y     = i_req.block_y;
        req_ent.block_z     = i_req.block_z;
        req_ent.notify      = i_req.notify_logic;
        req_ent.urgent      = i_req.is_urgent;
        req_ent.crack_stage = i_req.crack_stage;
        req_ent.crack_x     = i_req.crack_x;
        req_ent.crack_y     = i_req.crack_y;
        req_ent.crack_z     = i_req.crack_z;

        merge_ent        = req_ent;
        merge_ent.notify = i_rd_data.notify | i_req.notify_logic;
        merge_ent.urgent = i_rd_data.urgent | i_req.is_urgent;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cuuq_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_req.mode == cuuq_pkg::MODE_POP) begin
                        n_state = (r_cnt == '0) ? cuuq_pkg::S_DONE : cuuq_pkg::S_POP_SCAN;
                    end else begin
                        n_state = cuuq_pkg::S_ADD_SCAN;
                    end
                end
            end
            cuuq_pkg::S_ADD_SCAN: begin
                if (add_hit || drained) begin
                    n_state = cuuq_pkg::S_DONE;
                end
            end
            cuuq_pkg::S_POP_SCAN: begin
                if (urg_hit || drained) begin
                    n_state = cuuq_pkg::S_POP_SHIFT;
                end
            end
            cuuq_pkg::S_POP_SHIFT: begin
                if (drained) begin
                    n_state = cuuq_pkg::S_DONE;
                end
            end
            cuuq_pkg::S_DONE: begin
                if (i_rsp_ready) begin
                    n_state = cuuq_pkg::S_IDLE;
                end
            end
            default: n_state = cuuq_pkg::S_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_sel     = r_sel;
        n_ent     = r_ent;
        n_status  = r_status;
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx[IDX_W-1:0];
        o_wr_en   = 1'b0;
        o_wr_addr = r_sel;
        o_wr_data = r_ent;

        // Stream reads, one entry per cycle, while walking the queue
        if ((r_state == cuuq_pkg::S_ADD_SCAN) || (r_state == cuuq_pkg::S_POP_SCAN)
            || (r_state == cuuq_pkg::S_POP_SHIFT)) begin
            if (rd_more) begin
                o_rd_en = 1'b1;
                n_idx   = r_idx + 1'b1;
                n_pend  = 1'b1;
                n_pidx  = r_idx[IDX_W-1:0];
            end else begin
                n_pend = 1'b0;
            end
        end

        unique case (r_state)
            cuuq_pkg::S_IDLE: begin
                if (i_start) begin
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    n_status = cuuq_pkg::ST_EMPTY;
                end
            end
            cuuq_pkg::S_ADD_SCAN: begin
                if (add_hit) begin
                    // merge into the matching entry
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_pidx;
                    o_wr_data = merge_ent;
                    n_status  = cuuq_pkg::ST_MERGED;
                end else if (drained) begin
                    if (r_cnt >= DEPTH_C) begin
                        n_status = cuuq_pkg::ST_FULL;
                    end else begin
                        // append at the tail
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_cnt[IDX_W-1:0];
                        o_wr_data = req_ent;
                        n_cnt     = r_cnt + 1'b1;
                        n_status  = cuuq_pkg::ST_APPENDED;
                    end
                end
            end
            cuuq_pkg::S_POP_SCAN: begin
                // keep the head entry as the fallback when nothing is urgent
                if (r_pend && (r_pidx == '0)) begin
                    n_ent = i_rd_data;
                end
                if (urg_hit) begin
                    n_sel  = r_pidx;
                    n_ent  = i_rd_data;
                    n_idx  = CNT_W'(r_pidx) + 1'b1;
                    n_pend = 1'b0;
                end else if (drained) begin
                    n_sel  = '0;
                    n_idx  = CNT_W'(1);
                    n_pend = 1'b0;
                end
            end
            cuuq_pkg::S_POP_SHIFT: begin
                // move each later entry up by one place
                if (r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_pidx - 1'b1;
                    o_wr_data = i_rd_data;
                end
                if (drained) begin
                    n_cnt    = r_cnt - 1'b1;
                    n_status = cuuq_pkg::ST_POPPED;
                end
            end
            cuuq_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cuuq_pkg::S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pidx   <= n_pidx;
        r_sel    <= n_sel;
        r_ent    <= n_ent;
        r_status <= n_status;
    end

    // Format the response; only a pop carries entry data
    always_comb begin
        o_rsp        = '0;
        o_rsp.status = r_status;
        if (r_status == cuuq_pkg::ST_POPPED) begin
            o_rsp.out_block_x      = r_ent.block_x;
            o_rsp.out_block_y      = r_ent.block_y;
            o_rsp.out_block_z      = r_ent.block_z;
            o_rsp.out_notify_logic = r_ent.notify;
            o_rsp.out_crack_stage  = r_ent.crack_stage;
            o_rsp.out_crack_x      = r_ent.crack_x;
            o_rsp.out_crack_y      = r_ent.crack_y;
            o_rsp.out_crack_z      = r_ent.crack_z;
        end
        o_sts.done = (r_state == cuuq_pkg::S_DONE);
        o_sts.idle = (r_state == cuuq_pkg::S_IDLE);
    end

endmodule

// ===== bench/coalescing_urgent_update_queue_unit_checker.sv =====
// ----------------------------------------------------------------------------
// coalescing_urgent_update_queue_unit_checker
// Watches the request and response channels of the update queue, keeps a
// shadow copy of the queue, predicts each response and compares it field by
// field. Hands the failure count and the number of owed responses upward.
// ----------------------------------------------------------------------------
module coalescing_urgent_update_queue_unit_checker #(
    parameter int QUEUE_DEPTH = cuuq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_stall,
    input  cuuq_pkg::t_req i_req,
    input  logic           i_rsp_valid,
    input  logic           i_rsp_stall,
    input  cuuq_pkg::t_rsp i_rsp,
    output int             o_fail_count,
    output int             o_owed_count
);
    timeunit 1ns;
    timeprecision 1ps;

    cuuq_pkg::t_entry shadow_entry [QUEUE_DEPTH];
    int               shadow_count = 0;
    cuuq_pkg::t_rsp   owed_responses [$];
    int               fail_total = 0;

    // Apply one request to the shadow queue and return the response it owes
    function automatic cuuq_pkg::t_rsp update_shadow_queue(input cuuq_pkg::t_req r);
        cuuq_pkg::t_rsp   rsp;
        cuuq_pkg::t_entry e;
        int               hit;
        int               sel;
        int               k;
        rsp = '0;
        if (r.mode == cuuq_pkg::MODE_ADD) begin
            hit = -1;
            for (k = 0; k < shadow_count; k++) begin
                if (hit < 0 && {shadow_entry[k].block_x, shadow_entry[k].block_y,
                                shadow_entry[k].block_z} ==
                               {r.block_x, r.block_y, r.block_z}) begin
                    hit = k;
                end
            end
            if (hit >= 0) begin
                // Merge: refresh crack data, OR in notify and urgent
                shadow_entry[hit].notify      = shadow_entry[hit].notify | r.notify_logic;
                shadow_entry[hit].urgent      = shadow_entry[hit].urgent | r.is_urgent;
                shadow_entry[hit].crack_stage = r.crack_stage;
                shadow_entry[hit].crack_x     = r.crack_x;
                shadow_entry[hit].crack_y     = r.crack_y;
                shadow_entry[hit].crack_z     = r.crack_z;
                rsp.status = cuuq_pkg::ST_MERGED;
            end else if (shadow_count >= QUEUE_DEPTH) begin
                // Drop: queue full, state unchanged
                rsp.status = cuuq_pkg::ST_FULL;
            end else begin
                e.block_x     = r.block_x;
                e.block_y     = r.block_y;
                e.block_z     = r.block_z;
                e.notify      = r.notify_logic;
                e.urgent      = r.is_urgent;
                e.crack_stage = r.crack_stage;
                e.crack_x     = r.crack_x;
                e.crack_y     = r.crack_y;
                e.crack_z     = r.crack_z;
                shadow_entry[shadow_count] = e;
                shadow_count++;
                rsp.status = cuuq_pkg::ST_APPENDED;
            end
        end else if (shadow_count == 0) begin
            rsp.status = cuuq_pkg::ST_EMPTY;
        end else begin
            // Take the oldest urgent entry, else the oldest entry
            sel = -1;
            for (k = 0; k < shadow_count; k++) begin
                if (sel < 0 && shadow_entry[k].urgent) begin
                    sel = k;
                end
            end
            if (sel < 0) begin
                sel = 0;
            end
            e = shadow_entry[sel];
            rsp.status           = cuuq_pkg::ST_POPPED;
            rsp.out_block_x      = e.block_x;
            rsp.out_block_y      = e.block_y;
            rsp.out_block_z      = e.block_z;
            rsp.out_notify_logic = e.notify;
            rsp.out_crack_stage  = e.crack_stage;
            rsp.out_crack_x      = e.crack_x;
            rsp.out_crack_y      = e.crack_y;
            rsp.out_crack_z      = e.crack_z;
            // Close the gap, keep order of the rest
            for (k = sel; k < shadow_count - 1; k++) begin
                shadow_entry[k] = shadow_entry[k + 1];
            end
            shadow_count--;
        end
        return rsp;
    endfunction

    // Count a differing field, report the first few
    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            fail_total++;
            if (fail_total <= 10) begin
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
            end
        end
    endtask

    // Check accepted responses, then record accepted requests
    always @(posedge i_clk) begin : monitor
        cuuq_pkg::t_rsp want;
        if (!i_rst_n) begin
            shadow_count = 0;
            owed_responses.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (owed_responses.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("%0t: response with none owed: %h", $realtime, i_rsp);
                    end
                end else begin
                    want = owed_responses.pop_front();
                    compare_field("status",      16'(want.status),           16'(i_rsp.status));
                    compare_field("block_x",     16'(want.out_block_x),      16'(i_rsp.out_block_x));
                    compare_field("block_y",     16'(want.out_block_y),      16'(i_rsp.out_block_y));
                    compare_field("block_z",     16'(want.out_block_z),      16'(i_rsp.out_block_z));
                    compare_field("notify",      16'(want.out_notify_logic),
                                  16'(i_rsp.out_notify_logic));
                    compare_field("crack_stage", 16'(want.out_crack_stage),
                                  16'(i_rsp.out_crack_stage));
                    compare_field("crack_x",     want.out_crack_x,           i_rsp.out_crack_x);
                    compare_field("crack_y",     want.out_crack_y,           i_rsp.out_crack_y);
                    compare_field("crack_z",     want.out_crack_z,           i_rsp.out_crack_z);
                end
            end
            if (i_req_valid && !i_req_stall) begin
                owed_responses.insert(owed_responses.size(), update_shadow_queue(i_req));
            end
        end
        o_fail_count <= fail_total;
        o_owed_count <= owed_responses.size();
    end

endmodule

// ===== bench/coalescing_urgent_update_queue_unit_tb.sv =====
// ----------------------------------------------------------------------------
// coalescing_urgent_update_queue_unit_tb
// Drives add and pop requests into the update queue: a directed opening that
// covers empty pops, merges, urgency, a full queue and field extremes, then
// phases of random requests over a small position pool so that merges and
// drops are frequent. Both channels idle at random. A checker module beside
// the block predicts and compares every response.
// ----------------------------------------------------------------------------
module coalescing_urgent_update_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH           = cuuq_pkg::QUEUE_DEPTH_DEF;
    localparam int RANDOM_REQUESTS = 650;
    localparam int POOL_SIZE       = 20;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_req_valid;
    logic           o_req_stall;
    cuuq_pkg::t_req i_req;
    logic           o_rsp_valid;
    logic           i_rsp_stall = 1'b0;
    cuuq_pkg::t_rsp o_rsp;

    int   fail_count;
    int   owed_count;
    bit   idle_on = 1'b1;

    logic [35:0] position_pool [POOL_SIZE];

    coalescing_urgent_update_queue_unit #(
        .QUEUE_DEPTH (DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    coalescing_urgent_update_queue_unit_checker #(
        .QUEUE_DEPTH (DEPTH)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_stall  (o_req_stall),
        .i_req        (i_req),
        .i_rsp_valid  (o_rsp_valid),
        .i_rsp_stall  (i_rsp_stall),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_owed_count (owed_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stall the response side at random
    always @(negedge i_clk) begin
        i_rsp_stall <= idle_on && ($urandom_range(99) < 7);
    end

    initial begin
        #400000;
        $display("coalescing_urgent_update_queue_unit_tb NOT OK");
        $finish;
    end

    function automatic cuuq_pkg::t_req make_add(input logic [35:0] pos, input logic notify,
                                                input logic urgent, input logic [7:0] stage,
                                                input logic [47:0] crack);
        cuuq_pkg::t_req r;
        r = '0;
        r.mode = cuuq_pkg::MODE_ADD;
        {r.block_x, r.block_y, r.block_z} = pos;
        r.notify_logic = notify;
        r.is_urgent    = urgent;
        r.crack_stage  = stage;
        {r.crack_x, r.crack_y, r.crack_z} = crack;
        return r;
    endfunction

    function automatic cuuq_pkg::t_req make_pop();
        cuuq_pkg::t_req r;
        r = '0;
        r.mode = cuuq_pkg::MODE_POP;
        return r;
    endfunction

    // Random request, mostly over the position pool so entries collide
    function automatic cuuq_pkg::t_req make_random_request(input int add_percent);
        logic [95:0]    raw;
        cuuq_pkg::t_req r;
        raw = {$urandom, $urandom, $urandom};
        r = raw[$bits(cuuq_pkg::t_req)-1:0];
        r.mode = ($urandom_range(99) < add_percent) ? cuuq_pkg::MODE_ADD : cuuq_pkg::MODE_POP;
        if ($urandom_range(99) < 85) begin
            {r.block_x, r.block_y, r.block_z} = position_pool[$urandom_range(POOL_SIZE - 1)];
        end
        r.is_urgent = ($urandom_range(99) < 25);
        if ($urandom_range(99) < 80) begin
            r.crack_stage = 8'(int'($urandom_range(128)) - 1);
        end
        return r;
    endfunction

    // Present one request and hold it until accepted
    task automatic send_request(input cuuq_pkg::t_req r);
        while (idle_on && $urandom_range(99) < 7) begin
            @(negedge i_clk) i_req_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (o_req_stall);
    endtask

    // Drop valid and wait until every owed response has come back
    task automatic hold_until_drained();
        @(negedge i_clk) i_req_valid <= 1'b0;
        do @(posedge i_clk); while (owed_count != 0);
    endtask

    initial begin : stimulus
        logic [35:0] pos_a;
        logic [35:0] pos_b;
        int          add_percent;
        int          i;

        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;

        // Fill the position pool, extremes first
        position_pool[0] = {12'h800, 12'h800, 12'h800};
        position_pool[1] = {12'h7FF, 12'h7FF, 12'h7FF};
        position_pool[2] = {12'h800, 12'h7FF, 12'h000};
        position_pool[3] = '0;
        for (i = 4; i < POOL_SIZE; i++) begin
            position_pool[i] = 36'({$urandom, $urandom});
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Pop on an empty queue
        send_request(make_pop());
        // Append the two corner positions with extreme crack data
        pos_a = {12'h800, 12'h800, 12'h800};
        pos_b = {12'h7FF, 12'h7FF, 12'h7FF};
        send_request(make_add(pos_a, 1'b0, 1'b0, 8'hFF, {3{16'h8000}}));
        send_request(make_add(pos_b, 1'b1, 1'b1, 8'h7F, {3{16'h7FFF}}));
        // Merge: set notify on one, leave urgent set on the other
        send_request(make_add(pos_a, 1'b1, 1'b0, 8'h00, {16'h0000, 16'hFFFF, 16'h1234}));
        send_request(make_add(pos_b, 1'b0, 1'b0, 8'h80, {16'hFFFF, 16'h0000, 16'h8001}));
        // Fill the queue with distinct positions, a few urgent
        for (i = 0; i < DEPTH - 2; i++) begin
            send_request(make_add({12'(i * 100 - 700), 12'(-i), 12'(i)}, 1'(i),
                                  (i == 5 || i == 9), (i == 3) ? 8'h80 : 8'(i),
                                  {16'(i * 3001), 16'(-i * 77), 16'(i)}));
        end
        // Full queue: a new position drops, a known one still merges
        send_request(make_add({12'd1, 12'd2, 12'd3}, 1'b1, 1'b1, 8'h05, {3{16'h00AA}}));
        send_request(make_add({12'(2 * 100 - 700), 12'(-2), 12'(2)}, 1'b0, 1'b1, 8'h11,
                              {3{16'h5555}}));
        // Pops pick the oldest urgent entries
        send_request(make_pop());
        send_request(make_pop());

        hold_until_drained();

        // Random phases: add heavy, pop heavy, balanced
        for (i = 0; i < RANDOM_REQUESTS; i++) begin
            idle_on = !(i >= 250 && i < 400);
            if (i % 150 == 75) begin
                hold_until_drained();
            end
            case ((i / 40) % 3)
                0: begin
                    add_percent = 80;
                end
                1: begin
                    add_percent = 25;
                end
                default: begin
                    add_percent = 50;
                end
            endcase
            send_request(make_random_request(add_percent));
        end

        hold_until_drained();
        repeat (2 * (DEPTH + 4)) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("coalescing_urgent_update_queue_unit_tb OK");
        end else begin
            $display("coalescing_urgent_update_queue_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
